// ===== src/ctlhq_pkg.sv =====
// Shared types, constants and date functions for the temperature log hour query block.
package ctlhq_pkg;
  localparam int LogDepth  = 128;
  localparam int IdxW      = $clog2(LogDepth);
  localparam int CntW      = $clog2(LogDepth + 1);
  localparam int SlotCount = 12;
  localparam int SlotW     = 4;
  localparam int QDepth    = 2;

  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeQuery = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;
  localparam logic [1:0] ModeNone  = 2'd3;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
  } stamp_t;

  typedef struct packed {
    logic [1:0]  mode;
    stamp_t      stamp;
    logic [7:0]  first_temp;
    logic [7:0]  second_temp;
    logic        two_hour_step;
    logic        sensor_select;
  } cmd_t;

  typedef struct packed {
    logic [SlotW-1:0] slot_index;
    logic [4:0]       slot_hour;
    logic             slot_found;
    logic [7:0]       slot_temp;
    logic             last_slot;
  } res_t;

  function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
    logic        leap;
    logic [24:0] prod;
    logic [5:0]  cent;
    logic [11:0] rest;
    // y / 100 by reciprocal multiply, exact over the 12-bit year range
    prod = 25'(y) * 25'd5243;
    cent = prod[24:19];
    rest = y - 12'(12'(cent) * 12'd100);
    // divisible by 400 when divisible by 100 and the quotient by 4
    leap = (y[1:0] == 2'd0) && ((rest != 12'd0) || (cent[1:0] == 2'd0));
    unique case (m)
      4'd2: month_days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
      default: month_days = 5'd31;
    endcase
  endfunction

  // one slot step back in time
  function automatic stamp_t step_back(input stamp_t s, input logic two);
    stamp_t r;
    r = s;
    if (!two && s.hour > 5'd0) r.hour = s.hour - 5'd1;
    else if (two && s.hour > 5'd1) r.hour = s.hour - 5'd2;
    else begin
      r.hour = two ? 5'd22 : 5'd23;
      if (s.day > 5'd1) r.day = s.day - 5'd1;
      else begin
        if (s.month > 4'd1) r.month = s.month - 4'd1;
        else begin
          r.month = 4'd12;
          r.year = s.year - 12'd1;
        end
        r.day = month_days(r.year, r.month);
      end
    end
    return r;
  endfunction
endpackage

// ===== src/ctlhq_front.sv =====
// Input front end: takes items, drops unused modes, queues commands.
module ctlhq_front import ctlhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);
  cmd_t       mem [QDepth];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready = cnt != 2'(QDepth);
  assign push = in_valid && in_ready && in_cmd.mode != ModeNone;
  assign q_valid = cnt != 2'd0;
  assign pop = q_valid && q_ready;
  assign q_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_cmd;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== src/ctlhq_back.sv =====
// Back end: log store, slot builder, newest-to-oldest scan and result output.
module ctlhq_back import ctlhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);
  localparam logic [2:0] StIdle = 3'd0, StBuild = 3'd1, StScan = 3'd2,
                         StLast = 3'd3, StEmit = 3'd4;

  logic [41:0]      store [LogDepth];
  logic [41:0]      rd;
  logic [IdxW-1:0]  write_index, pos;
  logic [CntW-1:0]  record_count, left;
  logic [2:0]       state;
  stamp_t           cur;
  stamp_t           slot [SlotCount];
  logic             found [SlotCount];
  logic [7:0]       temp [SlotCount];
  logic [SlotW-1:0] si;
  logic             two, sel, rd_ok;
  stamp_t           rs;

  assign q_ready = state == StIdle;
  assign rs = rd[41:16];

  always_ff @(posedge clk) begin
    if (state == StIdle && q_valid && q_cmd.mode == ModeWrite)
      store[write_index] <= {q_cmd.stamp, q_cmd.first_temp, q_cmd.second_temp};
    rd <= store[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      write_index <= '0;
      record_count <= '0;
      out_valid <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      unique case (state)
        StIdle: if (q_valid) begin
          unique case (q_cmd.mode)
            ModeWrite: begin
              write_index <= (32'(write_index) == LogDepth - 1) ? '0 : write_index + 1'b1;
              if (32'(record_count) < LogDepth) record_count <= record_count + 1'b1;
            end
            ModeQuery: begin
              cur <= q_cmd.stamp;
              two <= q_cmd.two_hour_step;
              sel <= q_cmd.sensor_select;
              si <= '0;
              state <= StBuild;
            end
            default: begin
              write_index <= '0;
              record_count <= '0;
            end
          endcase
        end
        StBuild: begin
          slot[si] <= cur;
          found[si] <= 1'b0;
          temp[si] <= 8'd0;
          cur <= step_back(cur, two);
          si <= si + 1'b1;
          if (32'(si) == SlotCount - 1) begin
            state <= StScan;
            left <= record_count;
            pos <= (write_index == '0) ? IdxW'(LogDepth - 1) : write_index - 1'b1;
            rd_ok <= 1'b0;
          end
        end
        StScan, StLast: begin
          // rd holds the entry addressed in the previous cycle
          if (rd_ok) begin
            for (int i = 0; i < SlotCount; i++)
              if (rs == slot[i]) begin
                found[i] <= 1'b1;
                temp[i] <= sel ? rd[7:0] : rd[15:8];
              end
          end
          if (state == StLast) begin
            state <= StEmit;
            si <= '0;
            out_valid <= 1'b0;
          end else if (left == '0) begin
            rd_ok <= 1'b0;
            state <= StLast;
          end else begin
            rd_ok <= 1'b1;
            left <= left - 1'b1;
            pos <= (pos == '0) ? IdxW'(LogDepth - 1) : pos - 1'b1;
          end
        end
        StEmit: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_res <= '{si, slot[si].hour, found[si], temp[si],
                         32'(si) == SlotCount - 1};
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (out_res.last_slot) state <= StIdle;
            else si <= si + 1'b1;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

// ===== src/circular_temp_log_hour_query_core.sv =====
// Top level of the circular temperature log with hour-slot query.
// Write and clear pass through the command queue into the back end.
// Query: queue, accept, slot build for 12 slots, a scan of every stored record (up to 128)
// newest first, then 12 results, each held until taken.
// Synchronous active-high reset empties the queue and clears index and count;
// store contents are undefined until written.
module circular_temp_log_hour_query_core import ctlhq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[1:0], year[13:2], month[17:14], day[22:18], hour[27:23],
  // first_temp[35:28], second_temp[43:36], two_hour_step[44], sensor_select[45]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // slot_index[3:0], slot_hour[8:4], slot_found[9], slot_temp[17:10]
  output logic [23:0] m_tdata,
  output logic        m_tlast
);
  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_ready;

  assign in_cmd = '{s_tdata[1:0],
                    '{s_tdata[13:2], s_tdata[17:14], s_tdata[22:18], s_tdata[27:23]},
                    s_tdata[35:28], s_tdata[43:36], s_tdata[44], s_tdata[45]};

  ctlhq_front u_front (.clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
                       .in_cmd, .q_valid, .q_ready, .q_cmd);
  ctlhq_back u_back (.clk, .rst, .q_valid, .q_ready, .q_cmd,
                     .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res));

  assign m_tdata = {6'd0, res.slot_temp, res.slot_found, res.slot_hour, res.slot_index};
  assign m_tlast = res.last_slot;
endmodule

// ===== src/ctlhq_checker.sv =====
// Port-level checks for the temperature log query core.
module ctlhq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tlast == (m_tdata[3:0] == 4'd11))
    else $error("tlast not on twelfth slot");
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] < 4'd12)
    else $error("slot index out of range");
  a_temp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[9] |-> m_tdata[17:10] == 8'd0)
    else $error("temp without match");
endmodule

bind circular_temp_log_hour_query_core ctlhq_checker u_chk (.clk, .rst, .m_tvalid,
  .m_tready, .m_tdata, .m_tlast);
